FILE: rtl/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg: shared types, constants and tables of the activation unit
// Fixed-point format, cache geometry, queue entry layout and sigmoid tables.
// ----------------------------------------------------------------------------
package afb_pkg;

	localparam int FRAC_BITS = 12;
	localparam int DEPTH     = 4096;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CACHE_W   = 17;            // valid bit and cached y
	localparam int ONE_Q     = 1 << FRAC_BITS;

	// sigmoid table: 512 points at 1/64 steps, split into even and odd halves
	localparam int STEP_SH   = FRAC_BITS - 6;
	localparam int TBL_SIZE  = 512;
	localparam int TBL_IDX_W = $clog2(TBL_SIZE);
	localparam int HALF      = TBL_SIZE / 2;
	localparam int HALF_W    = $clog2(HALF);
	localparam int TV_W      = FRAC_BITS + 1;

	// magnitude of x or 2x, wide enough to flag the saturated region
	localparam int A_W  = (STEP_SH + TBL_IDX_W + 1 > 17) ? STEP_SH + TBL_IDX_W + 1 : 17;

	// datapath widths
	localparam int W_Y   = 18;
	localparam int M1_W  = 17;
	localparam int M2_W  = 35 - FRAC_BITS;
	localparam int SAT_W = 48;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] MODE_RELU    = 2'd0;
	localparam logic [1:0] MODE_SIGMOID = 2'd1;
	localparam logic [1:0] MODE_TANH    = 2'd2;

	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_BWD = 1'b1;

	localparam logic signed [SAT_W-1:0] SAT_MAX = 32767;
	localparam logic signed [SAT_W-1:0] SAT_MIN = -32768;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [TV_W-1:0]    tv_t;
	typedef tv_t [HALF-1:0]     tbl_half_t;
	typedef logic [HALF_W-1:0]  half_idx_t;

	typedef enum logic [2:0] {
		OP_FWD_RELU,
		OP_FWD_SIG,
		OP_FWD_TANH,
		OP_BWD_RELU,
		OP_BWD_SIG,
		OP_BWD_TANH
	} op_kind_t;

	typedef struct packed {
		logic               cmd;
		logic [11:0]        element_index;
		logic signed [15:0] value;
	} afb_in_t;

	typedef struct packed {
		logic signed [15:0] result;
		logic               error;
	} afb_out_t;

	// one classified transaction, as queued between front and back end
	typedef struct packed {
		op_kind_t           op;
		logic               bwd;
		logic               in_range;
		addr_t              addr;
		logic signed [15:0] value;
		tv_t                lo;
		tv_t                hi;
		logic [STEP_SH-1:0] frac;
		logic               over;
		logic               neg;
	} afb_op_t;

	// shift-subtract quotient, evaluated at elaboration only
	function automatic logic [63:0] udiv_bits(input logic [63:0] num,
		input logic [63:0] den, input int qbits);
		logic [63:0] rem;
		logic [63:0] q;
		rem = num;
		q = '0;
		for (int b = qbits - 1; b >= 0; b--) begin
			if ((den << b) <= rem) begin
				rem = rem - (den << b);
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// T[i] = round(ONE / (1 + e^(-i/64))), e^(-i/64) stepped in Q32
	function automatic tbl_half_t sig_half(input logic odd);
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		tbl_half_t h;
		r = 64'd1 << 32;
		t = r;
		e = r;
		h = '0;
		for (int k = 1; k <= 6; k++) begin
			t = udiv_bits(t, 64'(64 * k), 33);
			if ((k & 1) == 1) begin
				r = r - t;
			end else begin
				r = r + t;
			end
		end
		num = (64'd1 << 32) << FRAC_BITS;
		for (int i = 0; i < TBL_SIZE; i++) begin
			d = (64'd1 << 32) + e;
			if (((i & 1) == 1) == odd) begin
				h[i >> 1] = TV_W'(udiv_bits(num + (d >> 1), d, FRAC_BITS + 2));
			end
			e = (e * r) >> 32;
		end
		return h;
	endfunction

	localparam tbl_half_t SIG_EVEN = sig_half(1'b0);
	localparam tbl_half_t SIG_ODD  = sig_half(1'b1);

	function automatic logic signed [15:0] sat16(input logic signed [SAT_W-1:0] v);
		logic signed [15:0] r;
		if (v > SAT_MAX) begin
			r = 16'sh7fff;
		end else if (v < SAT_MIN) begin
			r = 16'sh8000;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

endpackage

FILE: rtl/afb_ram.sv
// ----------------------------------------------------------------------------
// afb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module afb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/afb_queue.sv
// ----------------------------------------------------------------------------
// afb_queue: short transaction queue between front and back end
// Flop-based FIFO; head is visible while not empty.
// ----------------------------------------------------------------------------
module afb_queue import afb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  afb_op_t push_data,
	input  logic    pop,
	output afb_op_t head,
	output logic    full,
	output logic    empty
);

	afb_op_t           slot_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/afb_front.sv
// ----------------------------------------------------------------------------
// afb_front: input handshake and transaction classification
// Decodes command and mode, splits |x| (or |2x|) into table index and
// fraction, and looks up the two sigmoid points around it.
// ----------------------------------------------------------------------------
module afb_front import afb_pkg::*; (
	input  logic       item_valid,
	output logic       item_ready,
	input  afb_in_t    item,
	input  logic [1:0] act_mode,
	input  logic       clearing,
	input  logic       q_full,
	output logic       push,
	output afb_op_t    push_data
);

	logic signed [A_W:0]    x2;
	logic [A_W-1:0]         mag;
	logic                   bwd;
	logic [TBL_IDX_W-1:0]   tidx;
	half_idx_t              hidx;
	half_idx_t              ev_addr;
	logic                   top_end;
	tv_t                    ev_val;
	tv_t                    od_val;
	op_kind_t               op;

	assign item_ready = !clearing && !q_full;
	assign push       = item_valid && item_ready;
	assign bwd        = (item.cmd == CMD_BWD);

	always_comb begin
		case (act_mode)
			MODE_SIGMOID: op = bwd ? OP_BWD_SIG : OP_FWD_SIG;
			MODE_TANH:    op = bwd ? OP_BWD_TANH : OP_FWD_TANH;
			MODE_RELU:    op = bwd ? OP_BWD_RELU : OP_FWD_RELU;
			default:      op = bwd ? OP_BWD_RELU : OP_FWD_RELU;
		endcase
	end

	// tanh evaluates the sigmoid at 2x
	assign x2  = (act_mode == MODE_TANH) ? ((A_W + 1)'(item.value) <<< 1)
	                                     : (A_W + 1)'(item.value);
	assign mag = x2[A_W] ? A_W'(-x2) : A_W'(x2);

	assign tidx = mag[STEP_SH + TBL_IDX_W - 1:STEP_SH];
	assign hidx = tidx[TBL_IDX_W-1:1];

	// even half is read one entry ahead for odd indices; past the end it is ONE
	assign ev_addr = hidx + HALF_W'(tidx[0]);
	assign top_end = tidx[0] && (hidx == '1);
	assign ev_val  = SIG_EVEN[ev_addr];
	assign od_val  = SIG_ODD[hidx];

	always_comb begin
		push_data.op       = op;
		push_data.bwd      = bwd;
		push_data.in_range = (32'(item.element_index) < 32'(DEPTH));
		push_data.addr     = addr_t'(item.element_index);
		push_data.value    = item.value;
		push_data.lo       = tidx[0] ? od_val : ev_val;
		push_data.hi       = tidx[0] ? (top_end ? TV_W'(ONE_Q) : ev_val) : od_val;
		push_data.frac     = mag[STEP_SH-1:0];
		push_data.over     = ((mag >> (STEP_SH + TBL_IDX_W)) != '0);
		push_data.neg      = x2[A_W];
	end

endmodule

FILE: rtl/afb_back.sv
// ----------------------------------------------------------------------------
// afb_back: execution pipeline, activation cache and output register
// s1: cache read data, first multiply; s2: forward result and cache write,
// second multiply; s3: scale and saturate; then the output register.
// ----------------------------------------------------------------------------
module afb_back import afb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  afb_op_t  head,
	input  logic     empty,
	output logic     pop,
	output logic     clearing,
	output logic     res_valid,
	input  logic     res_ready,
	output afb_out_t res
);

	logic                    adv;
	logic                    hazard;
	logic                    clearing_q;
	addr_t                   clr_q;

	logic                    vld_s1;
	logic                    vld_s2;
	logic                    vld_s3;
	afb_op_t                 ent_s1;
	afb_op_t                 ent_s2;

	logic                    ram_we;
	addr_t                   ram_waddr;
	logic [CACHE_W-1:0]      ram_wdata;
	logic [CACHE_W-1:0]      rd_data;

	logic signed [15:0]      c1;
	logic signed [TV_W:0]    diff1;
	logic signed [M1_W-1:0]  ma1;
	logic signed [M1_W-1:0]  mb1;
	logic signed [2*M1_W-1:0] m1;

	logic signed [2*M1_W-1:0] m1_s2;
	logic signed [15:0]      c_s2;
	logic                    cv_s2;

	logic signed [W_Y-1:0]   interp2;
	logic signed [W_Y-1:0]   sv2;
	logic signed [W_Y-1:0]   ys2;
	logic signed [W_Y-1:0]   yf2;
	logic signed [15:0]      fwd_res2;
	logic signed [15:0]      res2;
	logic                    err2;
	logic                    use_m2_2;
	logic signed [M2_W-1:0]  ma2;
	logic signed [M2_W-1:0]  mb2;
	logic signed [2*M2_W-1:0] m2;

	logic signed [2*M2_W-1:0] m2_s3;
	logic signed [15:0]      res_s3;
	logic                    err_s3;
	logic                    use_m2_s3;

	logic                    res_valid_q;
	afb_out_t                res_q;

	assign adv       = !res_valid_q || res_ready;
	assign clearing  = clearing_q;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// hold a backward read until an older forward to the same entry is written
	assign hazard = head.bwd && head.in_range &&
		((vld_s1 && !ent_s1.bwd && ent_s1.in_range && (ent_s1.addr == head.addr)) ||
		 (vld_s2 && !ent_s2.bwd && ent_s2.in_range && (ent_s2.addr == head.addr)));
	assign pop = adv && !empty && !hazard && !clearing_q;

	assign ram_we    = clearing_q || (adv && vld_s2 && !ent_s2.bwd && ent_s2.in_range);
	assign ram_waddr = clearing_q ? clr_q : ent_s2.addr;
	assign ram_wdata = clearing_q ? '0 : {1'b1, fwd_res2};

	afb_ram #(
		.WIDTH(CACHE_W),
		.DEPTH(DEPTH)
	) u_cache (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(head.addr),
		.rdata(rd_data)
	);

	// s1: interpolation slope times fraction, or the first gradient product
	assign c1    = $signed(rd_data[15:0]);
	assign diff1 = $signed({1'b0, ent_s1.hi}) - $signed({1'b0, ent_s1.lo});

	always_comb begin
		case (ent_s1.op)
			OP_FWD_SIG, OP_FWD_TANH: begin
				ma1 = M1_W'(diff1);
				mb1 = $signed(M1_W'(ent_s1.frac));
			end
			OP_BWD_TANH: begin
				ma1 = M1_W'(c1);
				mb1 = M1_W'(c1);
			end
			default: begin
				ma1 = M1_W'(ent_s1.value);
				mb1 = M1_W'(c1);
			end
		endcase
		m1 = ma1 * mb1;
	end

	// s2: finish the forward value; set up the second gradient product
	always_comb begin
		interp2 = W_Y'($signed({1'b0, ent_s2.lo})) + W_Y'(m1_s2 >>> STEP_SH);
		sv2     = ent_s2.over ? W_Y'(ONE_Q) : interp2;
		ys2     = ent_s2.neg ? W_Y'(ONE_Q) - sv2 : sv2;
		case (ent_s2.op)
			OP_FWD_SIG:  yf2 = ys2;
			OP_FWD_TANH: yf2 = (ys2 <<< 1) - W_Y'(ONE_Q);
			default:     yf2 = (ent_s2.value > 0) ? W_Y'(ent_s2.value) : '0;
		endcase
		fwd_res2 = sat16(SAT_W'(yf2));

		case (ent_s2.op)
			OP_BWD_SIG: begin
				ma2 = M2_W'(m1_s2 >>> FRAC_BITS);
				mb2 = M2_W'(ONE_Q) - M2_W'(c_s2);
			end
			OP_BWD_TANH: begin
				ma2 = M2_W'(ent_s2.value);
				mb2 = M2_W'(ONE_Q) - M2_W'(m1_s2 >>> FRAC_BITS);
			end
			default: begin
				ma2 = M2_W'(ent_s2.value);
				mb2 = M2_W'(c_s2);
			end
		endcase
		m2 = ma2 * mb2;

		err2     = ent_s2.bwd && (!ent_s2.in_range || !cv_s2);
		use_m2_2 = !err2 && ((ent_s2.op == OP_BWD_SIG) || (ent_s2.op == OP_BWD_TANH));

		if (!ent_s2.bwd) begin
			res2 = fwd_res2;
		end else if (!err2 && (ent_s2.op == OP_BWD_RELU) && (c_s2 > 0)) begin
			res2 = ent_s2.value;
		end else begin
			res2 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clr_q       <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == addr_t'(DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (adv) begin
				vld_s1      <= pop;
				vld_s2      <= vld_s1;
				vld_s3      <= vld_s2;
				res_valid_q <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ent_s1    <= head;
			ent_s2    <= ent_s1;
			m1_s2     <= m1;
			c_s2      <= c1;
			cv_s2     <= rd_data[CACHE_W-1];
			m2_s3     <= m2;
			res_s3    <= res2;
			err_s3    <= err2;
			use_m2_s3 <= use_m2_2;
			res_q.result <= use_m2_s3 ? sat16(SAT_W'(m2_s3 >>> FRAC_BITS)) : res_s3;
			res_q.error  <= err_s3;
		end
	end

endmodule

FILE: rtl/activation_fwd_bwd_unit.sv
// An accepted item passes the queue, stages s1, s2 and s3, and then the output register.
// Throughput: one item per cycle while results are taken and no hazard holds the queue. A
// backward transaction on an element whose forward transaction is still in the two stages
// before the cache write waits for that write. Reset: act_mode returns to ReLU; a sweep
// (one cache entry per cycle) clears the valid bits, with item_ready low until it ends.
// ----------------------------------------------------------------------------
// activation_fwd_bwd_unit: ReLU / sigmoid / tanh with cached gradient pass
// Front end classifies transactions into a short queue; the back end runs
// them through the multiply pipeline against the activation cache.
// ----------------------------------------------------------------------------
module activation_fwd_bwd_unit import afb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       item_valid,
	output logic       item_ready,
	input  afb_in_t    item,
	output logic       res_valid,
	input  logic       res_ready,
	output afb_out_t   res
);

	logic [1:0] act_mode_q;
	logic       clearing;
	logic       q_full;
	logic       q_empty;
	logic       push;
	logic       pop;
	afb_op_t    push_data;
	afb_op_t    head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= MODE_RELU;
		end else if (cfg_we) begin
			act_mode_q <= cfg_wdata;
		end
	end

	afb_front u_front (
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.act_mode  (act_mode_q),
		.clearing  (clearing),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	afb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	afb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.clearing (clearing),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule
